@@ sv/s2a_pkg.sv @@
`timescale 1ns / 1ps
package s2a_pkg;

  // Width of the signed input value
  localparam int DATA_BITS = 32;
  // Decimal digits of 2^(DATA_BITS-1); 30103/100000 approximates log10(2)
  localparam int DIGITS    = ((DATA_BITS - 1) * 30103) / 100000 + 1;
  localparam int CNT_W     = $clog2(DATA_BITS);
  localparam int REM_W     = $clog2(DIGITS + 1);
  localparam int CHAR_W    = 7;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

  typedef logic [3:0] bcd_t;

  // Shared control for every digit cell in the row
  typedef struct packed {
    logic clear;
    logic bit_shift;
    logic dig_shift;
  } cell_ctrl_t;

endpackage

@@ sv/s2a_in_if.sv @@
`timescale 1ns / 1ps
interface s2a_in_if
  import s2a_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ sv/s2a_out_if.sv @@
`timescale 1ns / 1ps
interface s2a_out_if
  import s2a_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink (input valid, input ascii_char, input last, output ready);
endinterface

@@ sv/s2a_cell.sv @@
`timescale 1ns / 1ps
module s2a_cell
  import s2a_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       bit_in,
  input  bcd_t       dig_in,
  output logic       bit_out,
  output bcd_t       digit
);

  bcd_t adj;

  // Add three to a digit of five or more before it doubles
  assign adj     = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign bit_out = adj[3];

  // Clear on load, shift one bit in while converting, take the lower digit while emitting
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.bit_shift) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctrl.dig_shift) begin
      digit <= dig_in;
    end
  end

endmodule

@@ sv/signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps
// Conversion: after an item is accepted, one magnitude bit enters the row per cycle; leading
//   zero digits, all but the last, are skipped before the first digit is offered.
// Items: a new item is accepted only in idle, after the last character of the previous one is
//   loaded for output; the row of 10 digit cells shifts bits in, then digits out.
// Reset: rst clears the sequencer and the output valid; the digit row needs no reset.
module signed_int_to_decimal_ascii_top
  import s2a_pkg::*;
(
  input logic       clk,
  input logic       rst,
  s2a_in_if.sink    num,
  s2a_out_if.source text
);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SIGN, ST_EMIT} state_t;

  state_t               state;
  logic [DATA_BITS-1:0] mag;
  logic                 neg;
  logic [CNT_W-1:0]     cnt;
  logic [REM_W-1:0]     rem;
  logic                 started;
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;

  cell_ctrl_t           ctrl;
  logic [DIGITS:0]      bit_chain;
  bcd_t                 digs [DIGITS];
  bcd_t                 top_dig;
  logic                 slot_free;
  logic                 skip;
  logic                 emit_now;
  logic [DATA_BITS-1:0] in_val;

  assign in_val    = DATA_BITS'(num.value);
  assign top_dig   = digs[DIGITS-1];
  assign slot_free = !out_valid || text.ready;
  assign skip      = !started && (top_dig == 4'd0) && (rem != REM_W'(1));
  assign emit_now  = slot_free && ((state == ST_SIGN) || ((state == ST_EMIT) && !skip));

  assign num.ready       = (state == ST_IDLE);
  assign text.valid      = out_valid;
  assign text.ascii_char = out_char;
  assign text.last       = out_last;

  // Drive the row of digit cells
  always_comb begin
    ctrl.clear     = num.valid && num.ready;
    ctrl.bit_shift = (state == ST_CONV);
    ctrl.dig_shift = (state == ST_EMIT) && (skip || slot_free);
  end

  assign bit_chain[0] = mag[DATA_BITS-1];

  // Digit cells, least significant first; bits carry upward, digits shift upward
  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    bcd_t dig_in;
    if (i == 0) begin : g_first
      assign dig_in = 4'd0;
    end else begin : g_rest
      assign dig_in = digs[i-1];
    end
    s2a_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .bit_in  (bit_chain[i]),
      .dig_in  (dig_in),
      .bit_out (bit_chain[i+1]),
      .digit   (digs[i])
    );
  end

  // Sequence load, conversion, sign and digit output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
      neg       <= 1'b0;
      cnt       <= '0;
      rem       <= '0;
    end else begin
      // Hold a character until taken; load the next one when the slot frees
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (num.valid) begin
            mag     <= in_val[DATA_BITS-1] ? DATA_BITS'(~in_val + 1'b1) : in_val;
            neg     <= in_val[DATA_BITS-1];
            cnt     <= CNT_W'(DATA_BITS - 1);
            started <= 1'b0;
            state   <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag <= {mag[DATA_BITS-2:0], 1'b0};
          if (cnt == '0) begin
            rem   <= REM_W'(DIGITS);
            state <= neg ? ST_SIGN : ST_EMIT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_char  <= CH_MINUS;
            out_last  <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip) begin
            rem <= rem - 1'b1;
          end else if (slot_free) begin
            out_char  <= CH_ZERO + CHAR_W'(top_dig);
            out_last  <= (rem == REM_W'(1));
            started   <= 1'b1;
            if (rem == REM_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              rem <= rem - 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The magnitude always fits the digit row: nothing carries out of the top cell
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !bit_chain[DIGITS])
    else $error("carry out of the top digit cell");

  // The digit counter never runs out while emitting
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (rem != '0))
    else $error("digit count reached zero while emitting");

  // A minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char == CH_MINUS) |-> !out_last)
    else $error("minus sign flagged as last");

  // Finishing an item returns to idle together with the last character
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !skip && slot_free && rem == REM_W'(1))
      |=> (state == ST_IDLE && out_valid && out_last))
    else $error("last character without return to idle");

endmodule

@@ verif/signed_int_to_decimal_ascii_top_tb.sv @@
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_top_tb;
  import s2a_pkg::*;

  localparam int SEND_ITEMS   = 400;
  // Receiver holds off here while the sender keeps offering items
  localparam int HOLD_START   = 3000;
  localparam int HOLD_CYCLES  = 600;
  // Neither side idles inside these windows
  localparam int CALM_FIRST   = 150;
  localparam int CALM_LAST    = 250;
  localparam int RX_CALM_FROM = 6000;
  localparam int RX_CALM_TO   = 12000;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 60;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [DATA_BITS-1:0] value_t;

  // Tracks the decimal text owed for each accepted value
  class decimal_text_tracker;
    typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
    } text_char_t;

    text_char_t  pending_chars[$];
    int unsigned errors;
    int unsigned values_seen;
    int unsigned negatives_seen;
    int unsigned chars_seen;
    int unsigned texts_seen;
    int unsigned run_len;
    int unsigned longest_run;

    function void flag_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    // Predict the characters of one value, most significant digit first
    function void note_value(value_t v);
      logic [DATA_BITS-1:0] raw;
      logic [DATA_BITS-1:0] mag;
      bcd_t                 digits[$];
      text_char_t           c;
      raw = v;
      mag = raw[DATA_BITS-1] ? -raw : raw;
      do begin
        digits.push_front(bcd_t'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      values_seen++;
      if (raw[DATA_BITS-1]) begin
        negatives_seen++;
        c.ch   = CH_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      foreach (digits[i]) begin
        c.ch   = CH_ZERO + digits[i];
        c.last = (i == digits.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    // Compare one delivered character with the oldest one owed
    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      text_char_t want;
      chars_seen++;
      run_len++;
      if (last) begin
        texts_seen++;
        if (run_len > longest_run) longest_run = run_len;
        run_len = 0;
      end
      if (pending_chars.size() == 0) begin
        flag_error($sformatf("unexpected char 0x%0h last=%0b", ch, last));
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) begin
        flag_error($sformatf("char: expected 0x%0h got 0x%0h", want.ch, ch));
      end
      if (last !== want.last) begin
        flag_error($sformatf("last: expected %0b got %0b", want.last, last));
      end
    endfunction

    // Anything still owed after the drain is missing output
    function void flush_leftover();
      while (pending_chars.size() != 0) begin
        void'(pending_chars.pop_front());
        flag_error("expected char never delivered");
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  s2a_in_if  num_if ();
  s2a_out_if text_if ();

  decimal_text_tracker text_board = new;
  int unsigned         rx_cycle;
  int unsigned         held_cycles;

  signed_int_to_decimal_ascii_top dut (
    .clk  (clk),
    .rst  (rst),
    .num  (num_if),
    .text (text_if)
  );

  always #2 clk = ~clk;

  // Note accepted values
  always @(posedge clk) begin
    if (!rst && num_if.valid && num_if.ready) begin
      text_board.note_value(num_if.value);
    end
  end

  // Check accepted characters
  always @(posedge clk) begin
    if (!rst && text_if.valid && text_if.ready) begin
      text_board.check_char(text_if.ascii_char, text_if.last);
    end
  end

  // Drive output ready: one long hold-off, one calm window, random stalls elsewhere
  initial begin
    text_if.ready <= 1'b0;
    rx_cycle      = 0;
    held_cycles   = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        text_if.ready <= 1'b0;
      end else begin
        rx_cycle++;
        if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
          held_cycles++;
          text_if.ready <= 1'b0;
        end else if (rx_cycle >= RX_CALM_FROM && rx_cycle < RX_CALM_TO) begin
          text_if.ready <= 1'b1;
        end else begin
          text_if.ready <= ($urandom_range(99) >= 9);
        end
      end
    end
  end

  // Pick a value: raw bits, a chosen digit count, or a spot near a limit or near zero
  function automatic value_t pick_value();
    logic [63:0]          bits;
    logic [63:0]          mag;
    logic [DATA_BITS-1:0] r;
    longint unsigned      lo;
    longint unsigned      hi;
    longint unsigned      top;
    int                   n;
    int                   kind;
    bits = {$urandom, $urandom};
    kind = $urandom_range(99);
    top  = (64'd1 << (DATA_BITS - 1)) - 1;
    if (kind < 40) begin
      r = bits[DATA_BITS-1:0];
    end else if (kind < 90) begin
      n  = $urandom_range(DIGITS, 1);
      lo = 1;
      repeat (n - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (lo == 1) lo = 0;
      if (hi > top) hi = top;
      mag = lo + bits % (hi - lo + 1);
      r   = mag[DATA_BITS-1:0];
      if ($urandom_range(1) == 1) r = -r;
    end else begin
      n = $urandom_range(15);
      case ($urandom_range(2))
        0:       r = {1'b1, {(DATA_BITS-1){1'b0}}} + n;
        1:       r = {1'b0, {(DATA_BITS-1){1'b1}}} - n;
        default: r = n - 8;
      endcase
    end
    return r;
  endfunction

  // Offer one value, after optional random idling, and hold it until accepted
  task automatic send_value(input value_t v, input bit may_idle);
    while (may_idle && $urandom_range(99) < 9) begin
      num_if.valid <= 1'b0;
      num_if.value <= value_t'($urandom);
      @(posedge clk);
    end
    num_if.valid <= 1'b1;
    num_if.value <= v;
    do @(posedge clk); while (!num_if.ready);
  endtask

  initial begin
    value_t directed[$];
    value_t v;
    num_if.valid <= 1'b0;
    num_if.value <= '0;
    rst          <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero, single digits, decade edges, other multi-digit values, both limits and alternating bits
    directed = '{value_t'(0), value_t'(1), value_t'(-1), value_t'(9), value_t'(10),
                 value_t'(-10), value_t'(99), value_t'(-100), value_t'(12345),
                 value_t'(-67890), value_t'(64'd1000000000), value_t'(-999999999),
                 {1'b0, {(DATA_BITS-1){1'b1}}}, {1'b1, {(DATA_BITS-1){1'b0}}},
                 {1'b1, {(DATA_BITS-2){1'b0}}, 1'b1},
                 {1'b0, {(DATA_BITS-2){1'b1}}, 1'b0},
                 {(DATA_BITS/2){2'b01}}, {(DATA_BITS/2){2'b10}}, value_t'(7),
                 value_t'(-5)};
    foreach (directed[i]) send_value(directed[i], 1'b1);

    for (int i = 0; i < SEND_ITEMS; i++) begin
      v = pick_value();
      send_value(v, !(i >= CALM_FIRST && i < CALM_LAST));
    end
    num_if.valid <= 1'b0;

    // Drain: wait for every owed character, then a further tail before checking for leftovers
    for (int w = 0; w < DRAIN_LIMIT && text_board.pending_chars.size() != 0; w++) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    text_board.flush_leftover();

    $display("Converted %0d values (%0d negative) into %0d texts, %0d chars.",
             text_board.values_seen, text_board.negatives_seen,
             text_board.texts_seen, text_board.chars_seen);
    $display("Longest text %0d chars; output held off %0d cycles; %0d errors.",
             text_board.longest_run, held_cycles, text_board.errors);
    if (text_board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #(400000 * 4);
    $display("Mismatches found");
    $finish;
  end

endmodule
